// ===== hdl/kpvb_pkg.sv =====
// Shared types, constants and the microcode program of the Kalman filter block.
`default_nettype none

package kpvb_pkg;

  // Word format: signed Q15.32
  localparam int WORD_W   = 48;
  localparam int FRAC     = 32;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int DVD_W    = WORD_W + FRAC;
  localparam int MCH_W    = 16;
  localparam int MCH_N    = (WORD_W + MCH_W - 1) / MCH_W;
  localparam int MCNT_W   = $clog2(MCH_N);
  localparam int DCNT_W   = $clog2(DVD_W);

  // Register file and microcode geometry
  localparam int RF_AW    = 5;
  localparam int RF_DEPTH = 1 << RF_AW;
  localparam int SRC_W    = RF_AW + 1;
  localparam int PC_W     = 7;

  // Configuration register fields
  localparam int TS_W      = 33;
  localparam int NS_W      = 47;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SIG  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_SIG   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR   = CFG_IDX_W'(3);

  localparam logic [TS_W-1:0] TS_RST = TS_W'(64'd42949673);
  localparam logic [NS_W-1:0] SA_RST = NS_W'(64'd4294967296);
  localparam logic [NS_W-1:0] SB_RST = NS_W'(64'd42949673);
  localparam logic [NS_W-1:0] RV_RST = NS_W'(64'd10737418);

  // Fixed-point constants
  localparam logic [WORD_W-1:0] Q_ONE  = WORD_W'(64'd1 << FRAC);
  localparam logic [WORD_W-1:0] Q_HALF = WORD_W'(64'd1 << (FRAC - 1));
  localparam logic [WORD_W-1:0] WMAX   = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WMIN   = {1'b1, {(WORD_W-1){1'b0}}};

  // Register file slots: filter state
  localparam logic [SRC_W-1:0] R_POS   = SRC_W'(0);
  localparam logic [SRC_W-1:0] R_VEL   = SRC_W'(1);
  localparam logic [SRC_W-1:0] R_BIAS  = SRC_W'(2);
  localparam logic [SRC_W-1:0] R_CPP   = SRC_W'(3);
  localparam logic [SRC_W-1:0] R_CPV   = SRC_W'(4);
  localparam logic [SRC_W-1:0] R_CPB   = SRC_W'(5);
  localparam logic [SRC_W-1:0] R_CVV   = SRC_W'(6);
  localparam logic [SRC_W-1:0] R_CVB   = SRC_W'(7);
  localparam logic [SRC_W-1:0] R_CBB   = SRC_W'(8);
  // Register file slots: scratch
  localparam logic [SRC_W-1:0] R_DT2   = SRC_W'(9);
  localparam logic [SRC_W-1:0] R_DT3   = SRC_W'(10);
  localparam logic [SRC_W-1:0] R_DT4   = SRC_W'(11);
  localparam logic [SRC_W-1:0] R_H     = SRC_W'(12);
  localparam logic [SRC_W-1:0] R_EA    = SRC_W'(13);
  localparam logic [SRC_W-1:0] R_PP    = SRC_W'(14);
  localparam logic [SRC_W-1:0] R_VP    = SRC_W'(15);
  localparam logic [SRC_W-1:0] R_T0    = SRC_W'(16);
  localparam logic [SRC_W-1:0] R_T1    = SRC_W'(17);
  localparam logic [SRC_W-1:0] R_A11   = SRC_W'(18);
  localparam logic [SRC_W-1:0] R_A12   = SRC_W'(19);
  localparam logic [SRC_W-1:0] R_A13   = SRC_W'(20);
  localparam logic [SRC_W-1:0] R_A22   = SRC_W'(21);
  localparam logic [SRC_W-1:0] R_A23   = SRC_W'(22);
  localparam logic [SRC_W-1:0] R_M11   = SRC_W'(23);
  localparam logic [SRC_W-1:0] R_M12   = SRC_W'(24);
  localparam logic [SRC_W-1:0] R_M22   = SRC_W'(25);
  localparam logic [SRC_W-1:0] R_M33   = SRC_W'(26);
  localparam logic [SRC_W-1:0] R_SA2   = SRC_W'(27);
  localparam logic [SRC_W-1:0] R_SB2   = SRC_W'(28);
  localparam logic [SRC_W-1:0] R_INNOV = SRC_W'(29);
  localparam logic [SRC_W-1:0] R_S     = SRC_W'(30);
  localparam logic [SRC_W-1:0] R_K1    = SRC_W'(31);
  // gains 2 and 3 reuse slots that are dead by the time the gains are formed
  localparam logic [SRC_W-1:0] R_K2    = SRC_W'(18);
  localparam logic [SRC_W-1:0] R_K3    = SRC_W'(21);

  // External operand sources (top bit set)
  localparam logic [SRC_W-1:0] X_Z     = SRC_W'(32);
  localparam logic [SRC_W-1:0] X_U     = SRC_W'(33);
  localparam logic [SRC_W-1:0] X_DT    = SRC_W'(34);
  localparam logic [SRC_W-1:0] X_SA    = SRC_W'(35);
  localparam logic [SRC_W-1:0] X_SB    = SRC_W'(36);
  localparam logic [SRC_W-1:0] X_RV    = SRC_W'(37);
  localparam logic [SRC_W-1:0] X_ZERO  = SRC_W'(38);
  localparam logic [SRC_W-1:0] X_ONE   = SRC_W'(39);
  localparam logic [SRC_W-1:0] X_HALF  = SRC_W'(40);

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHR1, OP_SHR2, OP_JNS, OP_SEED, OP_END
  } op_t;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_POS, OUT_VEL, OUT_BIAS
  } osel_t;

  typedef struct packed {
    op_t              op;
    logic [SRC_W-1:0] dst;
    logic [SRC_W-1:0] srca;
    logic [SRC_W-1:0] srcb;
    osel_t            osel;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic             busy;
    logic             alu_start;
    logic             wb;
    logic             done;
    op_t              op;
    logic [SRC_W-1:0] dst;
    logic [SRC_W-1:0] srca;
    logic [SRC_W-1:0] srcb;
    osel_t            osel;
  } ctl_t;

  localparam logic [PC_W-1:0] PC_MAIN = PC_W'(12);

  function automatic uword_t mk(input op_t op, input logic [SRC_W-1:0] d,
                                input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
                                input osel_t o);
    uword_t w;
    w.op     = op;
    w.dst    = d;
    w.srca   = a;
    w.srcb   = b;
    w.osel   = o;
    w.target = '0;
    return w;
  endfunction

  // Microcode program
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      // dispatch: already seeded goes to the full update
      PC_W'(0): begin
        w = mk(OP_JNS, R_T0, X_ZERO, X_ZERO, OUT_NONE);
        w.target = PC_MAIN;
      end
      // seed item
      PC_W'(1):  w = mk(OP_ADD, R_POS, X_Z, X_ZERO, OUT_POS);
      PC_W'(2):  w = mk(OP_ADD, R_VEL, X_ZERO, X_ZERO, OUT_VEL);
      PC_W'(3):  w = mk(OP_ADD, R_BIAS, X_ZERO, X_ZERO, OUT_BIAS);
      PC_W'(4):  w = mk(OP_ADD, R_CPP, X_ONE, X_ZERO, OUT_NONE);
      PC_W'(5):  w = mk(OP_ADD, R_CPV, X_ZERO, X_ZERO, OUT_NONE);
      PC_W'(6):  w = mk(OP_ADD, R_CPB, X_ZERO, X_ZERO, OUT_NONE);
      PC_W'(7):  w = mk(OP_ADD, R_CVV, X_ONE, X_ZERO, OUT_NONE);
      PC_W'(8):  w = mk(OP_ADD, R_CVB, X_ZERO, X_ZERO, OUT_NONE);
      PC_W'(9):  w = mk(OP_ADD, R_CBB, X_ONE, X_ZERO, OUT_NONE);
      PC_W'(10): w = mk(OP_SEED, R_T0, X_ZERO, X_ZERO, OUT_NONE);
      PC_W'(11): w = mk(OP_END, R_T0, X_ZERO, X_ZERO, OUT_NONE);
      // powers of dt and 0.5*dt^2
      PC_W'(12): w = mk(OP_MUL, R_DT2, X_DT, X_DT, OUT_NONE);
      PC_W'(13): w = mk(OP_MUL, R_DT3, R_DT2, X_DT, OUT_NONE);
      PC_W'(14): w = mk(OP_MUL, R_DT4, R_DT3, X_DT, OUT_NONE);
      PC_W'(15): w = mk(OP_MUL, R_H, X_HALF, R_DT2, OUT_NONE);
      // state prediction
      PC_W'(16): w = mk(OP_SUB, R_EA, X_U, R_BIAS, OUT_NONE);
      PC_W'(17): w = mk(OP_MUL, R_T0, R_VEL, X_DT, OUT_NONE);
      PC_W'(18): w = mk(OP_ADD, R_T0, R_POS, R_T0, OUT_NONE);
      PC_W'(19): w = mk(OP_MUL, R_T1, R_EA, R_H, OUT_NONE);
      PC_W'(20): w = mk(OP_ADD, R_PP, R_T0, R_T1, OUT_NONE);
      PC_W'(21): w = mk(OP_MUL, R_T0, R_EA, X_DT, OUT_NONE);
      PC_W'(22): w = mk(OP_ADD, R_VP, R_VEL, R_T0, OUT_NONE);
      // A*P
      PC_W'(23): w = mk(OP_MUL, R_T0, X_DT, R_CPV, OUT_NONE);
      PC_W'(24): w = mk(OP_ADD, R_T0, R_CPP, R_T0, OUT_NONE);
      PC_W'(25): w = mk(OP_MUL, R_T1, R_H, R_CPB, OUT_NONE);
      PC_W'(26): w = mk(OP_SUB, R_A11, R_T0, R_T1, OUT_NONE);
      PC_W'(27): w = mk(OP_MUL, R_T0, X_DT, R_CVV, OUT_NONE);
      PC_W'(28): w = mk(OP_ADD, R_T0, R_CPV, R_T0, OUT_NONE);
      PC_W'(29): w = mk(OP_MUL, R_T1, R_H, R_CVB, OUT_NONE);
      PC_W'(30): w = mk(OP_SUB, R_A12, R_T0, R_T1, OUT_NONE);
      PC_W'(31): w = mk(OP_MUL, R_T0, X_DT, R_CVB, OUT_NONE);
      PC_W'(32): w = mk(OP_ADD, R_T0, R_CPB, R_T0, OUT_NONE);
      PC_W'(33): w = mk(OP_MUL, R_T1, R_H, R_CBB, OUT_NONE);
      PC_W'(34): w = mk(OP_SUB, R_A13, R_T0, R_T1, OUT_NONE);
      PC_W'(35): w = mk(OP_MUL, R_T0, X_DT, R_CVB, OUT_NONE);
      PC_W'(36): w = mk(OP_SUB, R_A22, R_CVV, R_T0, OUT_NONE);
      PC_W'(37): w = mk(OP_MUL, R_T0, X_DT, R_CBB, OUT_NONE);
      PC_W'(38): w = mk(OP_SUB, R_A23, R_CVB, R_T0, OUT_NONE);
      // (A*P)*A^T
      PC_W'(39): w = mk(OP_MUL, R_T0, R_A12, X_DT, OUT_NONE);
      PC_W'(40): w = mk(OP_ADD, R_T0, R_A11, R_T0, OUT_NONE);
      PC_W'(41): w = mk(OP_MUL, R_T1, R_A13, R_H, OUT_NONE);
      PC_W'(42): w = mk(OP_SUB, R_M11, R_T0, R_T1, OUT_NONE);
      PC_W'(43): w = mk(OP_MUL, R_T0, R_A13, X_DT, OUT_NONE);
      PC_W'(44): w = mk(OP_SUB, R_M12, R_A12, R_T0, OUT_NONE);
      PC_W'(45): w = mk(OP_MUL, R_T0, R_A23, X_DT, OUT_NONE);
      PC_W'(46): w = mk(OP_SUB, R_M22, R_A22, R_T0, OUT_NONE);
      // process noise
      PC_W'(47): w = mk(OP_MUL, R_SA2, X_SA, X_SA, OUT_NONE);
      PC_W'(48): w = mk(OP_MUL, R_SB2, X_SB, X_SB, OUT_NONE);
      PC_W'(49): w = mk(OP_SHR2, R_T0, R_DT4, X_ZERO, OUT_NONE);
      PC_W'(50): w = mk(OP_MUL, R_T0, R_SA2, R_T0, OUT_NONE);
      PC_W'(51): w = mk(OP_ADD, R_M11, R_M11, R_T0, OUT_NONE);
      PC_W'(52): w = mk(OP_SHR1, R_T0, R_DT3, X_ZERO, OUT_NONE);
      PC_W'(53): w = mk(OP_MUL, R_T0, R_SA2, R_T0, OUT_NONE);
      PC_W'(54): w = mk(OP_ADD, R_M12, R_M12, R_T0, OUT_NONE);
      PC_W'(55): w = mk(OP_MUL, R_T0, R_SA2, R_DT2, OUT_NONE);
      PC_W'(56): w = mk(OP_ADD, R_M22, R_M22, R_T0, OUT_NONE);
      PC_W'(57): w = mk(OP_MUL, R_T0, R_SB2, R_DT2, OUT_NONE);
      PC_W'(58): w = mk(OP_ADD, R_M33, R_CBB, R_T0, OUT_NONE);
      // innovation and gains
      PC_W'(59): w = mk(OP_SUB, R_INNOV, X_Z, R_PP, OUT_NONE);
      PC_W'(60): w = mk(OP_ADD, R_S, R_M11, X_RV, OUT_NONE);
      PC_W'(61): w = mk(OP_DIV, R_K1, R_M11, R_S, OUT_NONE);
      PC_W'(62): w = mk(OP_DIV, R_K2, R_M12, R_S, OUT_NONE);
      PC_W'(63): w = mk(OP_DIV, R_K3, R_A13, R_S, OUT_NONE);
      // estimate update
      PC_W'(64): w = mk(OP_MUL, R_T0, R_K1, R_INNOV, OUT_NONE);
      PC_W'(65): w = mk(OP_ADD, R_POS, R_PP, R_T0, OUT_POS);
      PC_W'(66): w = mk(OP_MUL, R_T0, R_K2, R_INNOV, OUT_NONE);
      PC_W'(67): w = mk(OP_ADD, R_VEL, R_VP, R_T0, OUT_VEL);
      PC_W'(68): w = mk(OP_MUL, R_T0, R_K3, R_INNOV, OUT_NONE);
      PC_W'(69): w = mk(OP_ADD, R_BIAS, R_BIAS, R_T0, OUT_BIAS);
      // covariance update
      PC_W'(70): w = mk(OP_MUL, R_T0, R_K1, R_M11, OUT_NONE);
      PC_W'(71): w = mk(OP_SUB, R_CPP, R_M11, R_T0, OUT_NONE);
      PC_W'(72): w = mk(OP_MUL, R_T0, R_K1, R_M12, OUT_NONE);
      PC_W'(73): w = mk(OP_SUB, R_CPV, R_M12, R_T0, OUT_NONE);
      PC_W'(74): w = mk(OP_MUL, R_T0, R_K1, R_A13, OUT_NONE);
      PC_W'(75): w = mk(OP_SUB, R_CPB, R_A13, R_T0, OUT_NONE);
      PC_W'(76): w = mk(OP_MUL, R_T0, R_K2, R_M12, OUT_NONE);
      PC_W'(77): w = mk(OP_SUB, R_CVV, R_M22, R_T0, OUT_NONE);
      PC_W'(78): w = mk(OP_MUL, R_T0, R_K2, R_A13, OUT_NONE);
      PC_W'(79): w = mk(OP_SUB, R_CVB, R_A23, R_T0, OUT_NONE);
      PC_W'(80): w = mk(OP_MUL, R_T0, R_K3, R_A13, OUT_NONE);
      PC_W'(81): w = mk(OP_SUB, R_CBB, R_M33, R_T0, OUT_NONE);
      default:   w = mk(OP_END, R_T0, X_ZERO, X_ZERO, OUT_NONE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kpvb_regfile.sv =====
// Working register file: 32 words, one write port, two registered read ports.
`default_nettype none

module kpvb_regfile
  import kpvb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [RF_AW-1:0]  waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic [RF_AW-1:0]  raddr_a,
  input  wire logic [RF_AW-1:0]  raddr_b,
  output logic      [WORD_W-1:0] rdata_a,
  output logic      [WORD_W-1:0] rdata_b
);

  logic [WORD_W-1:0] mem [RF_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== hdl/kpvb_alu.sv =====
// Saturating fixed-point unit: add, subtract, shift, multi-cycle multiply and divide.
`default_nettype none

module kpvb_alu
  import kpvb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire op_t               op,
  input  wire logic [WORD_W-1:0] opnd_a,
  input  wire logic [WORD_W-1:0] opnd_b,
  output logic                   done,
  output logic      [WORD_W-1:0] result
);

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_MFIN, A_DIV, A_DFIN} ast_t;

  // saturate a magnitude with sign to the word range
  function automatic logic [WORD_W-1:0] sat_mag(input logic neg, input logic [DVD_W-1:0] m);
    logic [WORD_W-1:0] r;
    if (neg) begin
      if (m > DVD_W'({1'b0, WMIN})) r = WMIN;
      else                           r = WORD_W'(DVD_W'(0) - m);
    end else begin
      if (m > DVD_W'(WMAX)) r = WMAX;
      else                  r = WORD_W'(m);
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic sub);
    logic [WORD_W:0] s;
    logic [WORD_W-1:0] r;
    if (sub) s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    else     s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) r = s[WORD_W] ? WMIN : WMAX;
    else                          r = s[WORD_W-1:0];
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] a);
    return a[WORD_W-1] ? WORD_W'(0) - a : a;
  endfunction

  ast_t                      st_r;
  logic                      done_r;
  logic [WORD_W-1:0]         res_r;
  logic                      neg_r;
  logic [WORD_W-1:0]         ma_r;
  logic [MCH_N*MCH_W-1:0]    mb_r;
  logic [PROD_W-1:0]         acc_r;
  logic [DCNT_W-1:0]         cnt_r;
  logic [WORD_W-1:0]         ud_r;
  logic [DVD_W-1:0]          dvd_r;
  logic [WORD_W-1:0]         rem_r;
  logic [DVD_W-1:0]          q_r;

  // multiply: one 48x16 partial product per cycle
  logic [7:0]                msh;
  logic [MCH_W-1:0]          mchunk;
  logic [WORD_W+MCH_W-1:0]   mpart;
  logic [PROD_W-1:0]         mpart_sh;
  logic [PROD_W-1:0]         mrnd;
  always_comb begin
    msh      = 8'(cnt_r[MCNT_W-1:0]) * 8'(MCH_W);
    mchunk   = MCH_W'(mb_r >> msh);
    mpart    = ma_r * mchunk;
    mpart_sh = PROD_W'(mpart) << msh;
    mrnd     = acc_r + (PROD_W'(1) << (FRAC - 1));
  end

  // divide: one restoring step per cycle
  logic [WORD_W:0]  rsh;
  logic             dge;
  logic [WORD_W-1:0] rem_nxt;
  always_comb begin
    rsh     = {rem_r, dvd_r[DVD_W-1]};
    dge     = rsh >= {1'b0, ud_r};
    rem_nxt = dge ? WORD_W'(rsh - {1'b0, ud_r}) : rsh[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        A_IDLE: begin
          if (start) begin
            unique case (op)
              OP_ADD: begin
                res_r  <= sat_add(opnd_a, opnd_b, 1'b0);
                done_r <= 1'b1;
              end
              OP_SUB: begin
                res_r  <= sat_add(opnd_a, opnd_b, 1'b1);
                done_r <= 1'b1;
              end
              OP_SHR1: begin
                res_r  <= WORD_W'($signed(opnd_a) >>> 1);
                done_r <= 1'b1;
              end
              OP_SHR2: begin
                res_r  <= WORD_W'($signed(opnd_a) >>> 2);
                done_r <= 1'b1;
              end
              OP_MUL: begin
                neg_r <= opnd_a[WORD_W-1] ^ opnd_b[WORD_W-1];
                ma_r  <= mag(opnd_a);
                mb_r  <= (MCH_N*MCH_W)'(mag(opnd_b));
                acc_r <= '0;
                cnt_r <= '0;
                st_r  <= A_MUL;
              end
              OP_DIV: begin
                if (opnd_b == '0) begin
                  // zero divisor gives a zero gain
                  res_r  <= '0;
                  done_r <= 1'b1;
                end else begin
                  neg_r <= opnd_a[WORD_W-1] ^ opnd_b[WORD_W-1];
                  ud_r  <= mag(opnd_b);
                  dvd_r <= {mag(opnd_a), {FRAC{1'b0}}};
                  rem_r <= '0;
                  q_r   <= '0;
                  cnt_r <= '0;
                  st_r  <= A_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        A_MUL: begin
          acc_r <= acc_r + mpart_sh;
          cnt_r <= cnt_r + DCNT_W'(1);
          if (cnt_r == DCNT_W'(MCH_N - 1)) st_r <= A_MFIN;
        end
        A_MFIN: begin
          // round to nearest, ties away from zero, then saturate
          res_r  <= sat_mag(neg_r, DVD_W'(mrnd[PROD_W-1:FRAC]));
          done_r <= 1'b1;
          st_r   <= A_IDLE;
        end
        A_DIV: begin
          rem_r <= rem_nxt;
          q_r   <= {q_r[DVD_W-2:0], dge};
          dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
          cnt_r <= cnt_r + DCNT_W'(1);
          if (cnt_r == DCNT_W'(DVD_W - 1)) st_r <= A_DFIN;
        end
        A_DFIN: begin
          res_r  <= sat_mag(neg_r, q_r);
          done_r <= 1'b1;
          st_r   <= A_IDLE;
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

  // a new operation only starts on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == A_IDLE) else $error("alu started while busy");

  // completion is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("alu done held high");

endmodule

`default_nettype wire

// ===== hdl/kpvb_seq.sv =====
// Microcode sequencer: step counter, control word fetch and conditional jumps.
`default_nettype none

module kpvb_seq
  import kpvb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic out_free,
  input  wire logic alu_done,
  output ctl_t      ctl
);

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_READ, S_EXEC, S_WAIT} st_t;

  st_t             st_r, st_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          uw_r, uw_nxt;
  logic            seeded_r, seeded_nxt;

  // next-state logic
  always_comb begin
    st_nxt     = st_r;
    pc_nxt     = pc_r;
    uw_nxt     = uw_r;
    seeded_nxt = seeded_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          pc_nxt = '0;
          st_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        uw_nxt = ucode(pc_r);
        st_nxt = S_READ;
      end
      S_READ: begin
        unique case (uw_r.op)
          OP_JNS: begin
            pc_nxt = seeded_r ? uw_r.target : pc_r + PC_W'(1);
            st_nxt = S_FETCH;
          end
          OP_SEED: begin
            seeded_nxt = 1'b1;
            pc_nxt     = pc_r + PC_W'(1);
            st_nxt     = S_FETCH;
          end
          OP_END: begin
            if (out_free) st_nxt = S_IDLE;
          end
          default: st_nxt = S_EXEC;
        endcase
      end
      S_EXEC: st_nxt = S_WAIT;
      S_WAIT: begin
        if (alu_done) begin
          pc_nxt = pc_r + PC_W'(1);
          st_nxt = S_FETCH;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      pc_r     <= '0;
      seeded_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      pc_r     <= pc_nxt;
      seeded_r <= seeded_nxt;
      uw_r     <= uw_nxt;
    end
  end

  // control word decode
  always_comb begin
    ctl.busy      = st_r != S_IDLE;
    ctl.alu_start = st_r == S_EXEC;
    ctl.wb        = (st_r == S_WAIT) && alu_done;
    ctl.done      = (st_r == S_READ) && (uw_r.op == OP_END) && out_free;
    ctl.op        = uw_r.op;
    ctl.dst       = uw_r.dst;
    ctl.srca      = uw_r.srca;
    ctl.srcb      = uw_r.srcb;
    ctl.osel      = uw_r.osel;
  end

  // write-back only for steps that ran through the arithmetic unit
  a_wb_alu_op: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wb |-> (uw_r.op == OP_ADD || uw_r.op == OP_SUB || uw_r.op == OP_MUL ||
                uw_r.op == OP_DIV || uw_r.op == OP_SHR1 || uw_r.op == OP_SHR2))
    else $error("write-back on a control step");

  // program end returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> st_r == S_IDLE) else $error("sequencer not idle after end");

endmodule

`default_nettype wire

// ===== hdl/kalman_pos_vel_bias_filter_top.sv =====
// Top level of the three-state position/velocity/bias Kalman filter.
// Each input word (measured position, commanded acceleration) yields one output word
// with the updated position, velocity and bias estimates, all signed Q15.32. The first
// word after reset only seeds the state: it runs 12 microcode steps. Every later word
// runs 72 steps of the predict/update program: three bit-serial divides (80 restoring
// steps each), 34 multiplies, 33 add, subtract and shift steps, and the dispatch and
// end steps. Every arithmetic step passes through the fetch, register read and issue
// states before the arithmetic unit runs. One word is in flight at a time: in_tready is
// high while the sequencer is idle, and a finished result waits in the output register
// while the next word is accepted. The end step waits while the output register is
// still full, so a receiver that holds off delays the return to idle. Configuration
// writes are accepted at any time but must only be made while the block is idle.
`default_nettype none

module kalman_pos_vel_bias_filter_top
  import kpvb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [2*WORD_W-1:0]  in_tdata,  // measured_position, accel_command
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [3*WORD_W-1:0]  out_tdata, // position_est, velocity_est, bias_est
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [NS_W-1:0]      cfg_data
);

  ctl_t              ctl;
  logic              in_acc;
  logic              out_free;
  logic              alu_done;
  logic [WORD_W-1:0] alu_res;
  logic [WORD_W-1:0] rd_a, rd_b;
  logic [WORD_W-1:0] opnd_a, opnd_b;

  logic [TS_W-1:0]   ts_r;
  logic [NS_W-1:0]   sa_r, sb_r, rv_r;
  logic [WORD_W-1:0] z_r, u_r;
  logic [WORD_W-1:0] res_pos_r, res_vel_r, res_bias_r;
  logic [WORD_W-1:0] out_pos_r, out_vel_r, out_bias_r;
  logic              out_tvalid_r;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = !ctl.busy;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RST;
      sa_r <= SA_RST;
      sb_r <= SB_RST;
      rv_r <= RV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIME_STEP: ts_r <= TS_W'(cfg_data);
        CFG_ACCEL_SIG: sa_r <= cfg_data;
        CFG_BIAS_SIG:  sb_r <= cfg_data;
        CFG_MEAS_VAR:  rv_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      z_r <= in_tdata[WORD_W-1:0];
      u_r <= in_tdata[2*WORD_W-1:WORD_W];
    end
  end

  // operand select: register file or external source
  function automatic logic [WORD_W-1:0] pick(input logic [SRC_W-1:0] s,
                                             input logic [WORD_W-1:0] rd);
    logic [WORD_W-1:0] v;
    unique case (s)
      X_Z:     v = z_r;
      X_U:     v = u_r;
      X_DT:    v = WORD_W'(ts_r);
      X_SA:    v = WORD_W'(sa_r);
      X_SB:    v = WORD_W'(sb_r);
      X_RV:    v = WORD_W'(rv_r);
      X_ZERO:  v = '0;
      X_ONE:   v = Q_ONE;
      X_HALF:  v = Q_HALF;
      default: v = rd;
    endcase
    return v;
  endfunction

  always_comb begin
    opnd_a = pick(ctl.srca, rd_a);
    opnd_b = pick(ctl.srcb, rd_b);
  end

  kpvb_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .out_free (out_free),
    .alu_done (alu_done),
    .ctl      (ctl)
  );

  kpvb_regfile u_rf (
    .clk     (clk),
    .we      (ctl.wb),
    .waddr   (ctl.dst[RF_AW-1:0]),
    .wdata   (alu_res),
    .raddr_a (ctl.srca[RF_AW-1:0]),
    .raddr_b (ctl.srcb[RF_AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  kpvb_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctl.alu_start),
    .op     (ctl.op),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .done   (alu_done),
    .result (alu_res)
  );

  // staging of final estimates as they are written back
  always_ff @(posedge clk) begin
    if (ctl.wb) begin
      unique case (ctl.osel)
        OUT_POS:  res_pos_r  <= alu_res;
        OUT_VEL:  res_vel_r  <= alu_res;
        OUT_BIAS: res_bias_r <= alu_res;
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      if (ctl.done) begin
        out_tvalid_r <= 1'b1;
        out_pos_r    <= res_pos_r;
        out_vel_r    <= res_vel_r;
        out_bias_r   <= res_bias_r;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_bias_r, out_vel_r, out_pos_r};

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |-> (!out_tvalid_r || out_tready)) else $error("result overwritten");

  // an accepted word starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ctl.busy) else $error("sequencer did not start");

endmodule

`default_nettype wire

// ===== verif/kalman_pos_vel_bias_filter_top_test.sv =====
// Self-checking testbench for the position/velocity/bias Kalman filter top level.

module kalman_pos_vel_bias_filter_top_test;
  import kpvb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint W_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint W_MIN = -W_MAX - 1;
  localparam longint Q1    = 64'sh1_0000_0000;
  localparam int     TRACE_LIMIT = 10;

  typedef struct packed {
    logic [WORD_W-1:0] bias;
    logic [WORD_W-1:0] vel;
    logic [WORD_W-1:0] pos;
  } estimate_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [2*WORD_W-1:0]  in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [3*WORD_W-1:0]  out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NS_W-1:0]      cfg_data;

  // predictor copy of configuration and filter state
  longint dt_q, sa_q, sb_q, rv_q;
  longint est_pos, est_vel, est_bias;
  longint p_pp, p_pv, p_pb, p_vv, p_vb, p_bb;
  bit     is_seeded;

  estimate_t expected_estimates[$];
  int        fail_count;
  int        mismatch_count;
  bit        idle_on;
  int        rx_hold_cycles;

  kalman_pos_vel_bias_filter_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------- fixed-point arithmetic ----------------
  function automatic longint clampw(input longint x);
    if (x > W_MAX) return W_MAX;
    if (x < W_MIN) return W_MIN;
    return x;
  endfunction

  function automatic longint q_add(input longint a, input longint b);
    return clampw(a + b);
  endfunction

  function automatic longint q_sub(input longint a, input longint b);
    return clampw(a - b);
  endfunction

  function automatic longint from_magnitude(input bit neg, input logic [127:0] m);
    if (neg) begin
      if (m > 128'(W_MAX) + 1) return W_MIN;
      return -longint'(m[63:0]);
    end
    if (m > 128'(W_MAX)) return W_MAX;
    return longint'(m[63:0]);
  endfunction

  // product rounded to nearest, ties away from zero
  function automatic longint q_mul(input longint a, input longint b);
    logic [63:0]  ma, mb;
    logic [127:0] m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = 128'(ma) * 128'(mb);
    m = (m + (128'd1 << (FRAC - 1))) >> FRAC;
    return from_magnitude((a < 0) != (b < 0), m);
  endfunction

  // quotient truncated toward zero; zero divisor gives zero
  function automatic longint q_div(input longint n, input longint d);
    logic [63:0]  mn, md;
    logic [127:0] m;
    if (d == 0) return 0;
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    m = (128'(mn) << FRAC) / 128'(md);
    return from_magnitude((n < 0) != (d < 0), m);
  endfunction

  function automatic longint sext_word(input logic [WORD_W-1:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic reset_model();
    dt_q = 42949673;
    sa_q = Q1;
    sb_q = 42949673;
    rv_q = 10737418;
    est_pos = 0; est_vel = 0; est_bias = 0;
    p_pp = Q1; p_vv = Q1; p_bb = Q1;
    p_pv = 0; p_pb = 0; p_vb = 0;
    is_seeded = 0;
  endtask

  // one filter iteration; returns the new estimates
  function automatic estimate_t filter_update(input logic [WORD_W-1:0] z_raw,
                                              input logic [WORD_W-1:0] u_raw);
    longint z, u, dt2, dt3, dt4, h, ea, pp, vp;
    longint a11, a12, a13, a22, a23, m11, m12, m13, m22, m23, m33;
    longint sa2, sb2, innov, s, k1, k2, k3;
    estimate_t r;
    z = sext_word(z_raw);
    u = sext_word(u_raw);
    if (!is_seeded) begin
      est_pos = z; est_vel = 0; est_bias = 0;
      is_seeded = 1;
    end else begin
      dt2 = q_mul(dt_q, dt_q);
      dt3 = q_mul(dt2, dt_q);
      dt4 = q_mul(dt3, dt_q);
      h   = q_mul(Q1 / 2, dt2);
      // state prediction
      ea = q_sub(u, est_bias);
      pp = q_add(q_add(est_pos, q_mul(est_vel, dt_q)), q_mul(ea, h));
      vp = q_add(est_vel, q_mul(ea, dt_q));
      // A P A^T
      a11 = q_sub(q_add(p_pp, q_mul(dt_q, p_pv)), q_mul(h, p_pb));
      a12 = q_sub(q_add(p_pv, q_mul(dt_q, p_vv)), q_mul(h, p_vb));
      a13 = q_sub(q_add(p_pb, q_mul(dt_q, p_vb)), q_mul(h, p_bb));
      a22 = q_sub(p_vv, q_mul(dt_q, p_vb));
      a23 = q_sub(p_vb, q_mul(dt_q, p_bb));
      m11 = q_sub(q_add(a11, q_mul(a12, dt_q)), q_mul(a13, h));
      m12 = q_sub(a12, q_mul(a13, dt_q));
      m13 = a13;
      m22 = q_sub(a22, q_mul(a23, dt_q));
      m23 = a23;
      m33 = p_bb;
      // process noise
      sa2 = q_mul(sa_q, sa_q);
      sb2 = q_mul(sb_q, sb_q);
      m11 = q_add(m11, q_mul(sa2, dt4 >>> 2));
      m12 = q_add(m12, q_mul(sa2, dt3 >>> 1));
      m22 = q_add(m22, q_mul(sa2, dt2));
      m33 = q_add(m33, q_mul(sb2, dt2));
      // measurement update
      innov = q_sub(z, pp);
      s  = q_add(m11, rv_q);
      k1 = q_div(m11, s);
      k2 = q_div(m12, s);
      k3 = q_div(m13, s);
      est_pos  = q_add(pp, q_mul(k1, innov));
      est_vel  = q_add(vp, q_mul(k2, innov));
      est_bias = q_add(est_bias, q_mul(k3, innov));
      p_pp = q_sub(m11, q_mul(k1, m11));
      p_pv = q_sub(m12, q_mul(k1, m12));
      p_pb = q_sub(m13, q_mul(k1, m13));
      p_vv = q_sub(m22, q_mul(k2, m12));
      p_vb = q_sub(m23, q_mul(k2, m13));
      p_bb = q_sub(m33, q_mul(k3, m13));
    end
    r.pos  = est_pos[WORD_W-1:0];
    r.vel  = est_vel[WORD_W-1:0];
    r.bias = est_bias[WORD_W-1:0];
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic idle_burst_tx();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      in_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // offer one word and wait for it to be taken
  task automatic send_sample(input logic [WORD_W-1:0] z, input logic [WORD_W-1:0] u);
    @(negedge clk);
    idle_burst_tx();
    in_tvalid = 1'b1;
    in_tdata  = {u, z};
    do @(posedge clk); while (!in_tready);
    expected_estimates.push_back(filter_update(z, u));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_estimates.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [NS_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TIME_STEP: dt_q = longint'(val[TS_W-1:0]);
      CFG_ACCEL_SIG: sa_q = longint'(val);
      CFG_BIAS_SIG:  sb_q = longint'(val);
      CFG_MEAS_VAR:  rv_q = longint'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic cfg_all(input longint dt, input longint sa, input longint sb,
                         input longint rv);
    cfg_write(CFG_TIME_STEP, NS_W'(dt));
    cfg_write(CFG_ACCEL_SIG, NS_W'(sa));
    cfg_write(CFG_BIAS_SIG, NS_W'(sb));
    cfg_write(CFG_MEAS_VAR, NS_W'(rv));
  endtask

  function automatic logic [WORD_W-1:0] any_word();
    return WORD_W'({$urandom, $urandom});
  endfunction

  // measurement near the current estimate, moderate command
  function automatic logic [WORD_W-1:0] near_position();
    longint off;
    off = longint'($urandom_range(0, 32'hFFFF_FFFF)) * 4 - (64'sd1 << 33);
    return WORD_W'(clampw(est_pos + off));
  endfunction

  function automatic logic [WORD_W-1:0] mild_accel();
    return WORD_W'(longint'($urandom_range(0, 32'hFFFF_FFFF)) * 8 - (64'sd1 << 34));
  endfunction

  // ---------------- result receiver ----------------
  always @(negedge clk) begin
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall = 0;
    end else if (rx_hold_cycles > 0) begin
      out_tready <= 1'b0;
      rx_hold_cycles--;
    end else if (stall > 0) begin
      out_tready <= 1'b0;
      stall--;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) stall = $urandom_range(1, 8);
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin
    estimate_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_estimates.size() == 0) begin
        fail_count++;
        if (mismatch_count < TRACE_LIMIT)
          $display("unexpected result word pos=%h vel=%h bias=%h",
                   got.pos, got.vel, got.bias);
        mismatch_count++;
      end else begin
        want = expected_estimates.pop_front();
        if (got !== want) begin
          fail_count++;
          if (mismatch_count < TRACE_LIMIT)
            $display("mismatch pos exp=%h got=%h vel exp=%h got=%h bias exp=%h got=%h",
                     want.pos, got.pos, want.vel, got.vel, want.bias, got.bias);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_seed_and_field_extremes();
    send_sample(WORD_W'(W_MAX), WORD_W'(W_MIN));   // seeding word
    send_sample(WORD_W'(W_MAX), WORD_W'(W_MAX));
    send_sample(WORD_W'(W_MIN), WORD_W'(W_MIN));
    send_sample('0, '0);
    send_sample(WORD_W'(-1), WORD_W'(1));
    send_sample(WORD_W'(W_MIN), WORD_W'(W_MAX));
    send_sample(WORD_W'(Q1), WORD_W'(-Q1));
    wait_idle();
  endtask

  task automatic test_config_extremes();
    // zero step, zero noise, smallest measurement variance
    cfg_all(0, 0, 0, 1);
    send_sample(WORD_W'(Q1), WORD_W'(Q1));
    send_sample(WORD_W'(-Q1), '0);
    wait_idle();
    // unit step and largest noise: saturating covariance
    cfg_all(64'sh1_0000_0000, W_MAX, W_MAX, W_MAX);
    send_sample(WORD_W'(W_MAX), WORD_W'(W_MIN));
    send_sample('0, WORD_W'(W_MAX));
    send_sample(WORD_W'(W_MIN), '0);
    wait_idle();
    // large step, small measurement variance: gains near one, possibly negative variance
    cfg_all(64'sh0_8000_0000, Q1, 64'sh0_1000_0000, 1);
    send_sample(WORD_W'(3 * Q1), WORD_W'(-2 * Q1));
    send_sample(WORD_W'(-5 * Q1), WORD_W'(7 * Q1));
    send_sample('0, '0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    cfg_all(42949673, Q1, 42949673, 10737418);
    @(negedge clk);
    rx_hold_cycles = 3000;
    repeat (8) send_sample(near_position(), mild_accel());
    wait_idle();
  endtask

  task automatic test_random(input int n_phases, input int per_phase);
    longint dt, sa, sb, rv;
    for (int ph = 0; ph < n_phases; ph++) begin
      case ($urandom_range(0, 5))
        0: dt = longint'($urandom_range(0, 1)) << 32;
        1: dt = longint'({$urandom_range(0, 1), $urandom});
        default: dt = $urandom_range(4294967, 429496730);
      endcase
      sa = ($urandom_range(0, 4) == 0) ? longint'(NS_W'({$urandom, $urandom}))
                                       : longint'($urandom_range(0, 32'hFFFF_FFFF)) * 4;
      sb = ($urandom_range(0, 4) == 0) ? longint'(NS_W'({$urandom, $urandom}))
                                       : $urandom_range(0, 32'h7FFF_FFFF);
      rv = ($urandom_range(0, 4) == 0) ? longint'(NS_W'({$urandom, $urandom}))
                                       : $urandom_range(1, 32'h7FFF_FFFF);
      if (rv == 0) rv = 1;
      cfg_all(dt, sa, sb, rv);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 3) != 0) send_sample(near_position(), mild_accel());
        else send_sample(any_word(), any_word());
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_TIME_STEP;
    cfg_data   = '0;
    fail_count = 0;
    mismatch_count = 0;
    idle_on    = 1'b1;
    rx_hold_cycles = 0;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_seed_and_field_extremes();
    test_config_extremes();
    test_backpressure();
    test_random(16, 100);
    idle_on = 1'b0;
    test_random(2, 100);

    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #400_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
